// File: rtl/assert_macros.svh
// Assertion macros shared by the translator modules.
// Depends on nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge while reset is released.
`define EBPF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("translator check failed");

// Checks that a condition on one edge implies another on the next edge.
`define EBPF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("translator sequence check failed");

`endif

// File: rtl/ebpfx86_pkg.sv
// Shared types, codes, byte tables and encoding helpers for the translator.
// Depends on nothing; imported by every module of the block.
package ebpfx86_pkg;

  // Item kinds carried on the input user field.
  typedef enum logic [1:0] {
    OP_XLATE  = 2'd0,
    OP_START  = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  // Instruction classes and operation fields.
  localparam logic [2:0] CLS_LDX   = 3'h1;
  localparam logic [2:0] CLS_STX   = 3'h3;
  localparam logic [2:0] CLS_JMP   = 3'h5;
  localparam logic [2:0] CLS_ALU64 = 3'h7;
  localparam logic [3:0] OPF_ADD   = 4'h0;
  localparam logic [3:0] OPF_MOV   = 4'hB;
  localparam logic [3:0] OPF_JA    = 4'h0;
  localparam logic [3:0] OPF_EXIT  = 4'h9;
  localparam logic [1:0] SIZE_DW   = 2'b11;
  localparam logic [7:0] WIDE_OPCODE = 8'h18;

  // x86-64 opcode bytes.
  localparam logic [7:0] X_REX_W     = 8'h48;
  localparam logic [7:0] X_MOV_RM_R  = 8'h89;
  localparam logic [7:0] X_MOV_RM_I  = 8'hC7;
  localparam logic [7:0] X_ADD_RM_I  = 8'h81;
  localparam logic [7:0] X_ADD_RM_R  = 8'h01;
  localparam logic [7:0] X_MOV_R_RM  = 8'h8B;
  localparam logic [7:0] X_MOV_R_IMM = 8'hB8;
  localparam logic [7:0] X_JMP_REL32 = 8'hE9;

  localparam int MAX_BYTES     = 11;
  localparam int PROLOGUE_LEN  = 11;
  localparam int EPILOGUE_LEN  = 9;
  localparam int Q_DEPTH_DEFAULT = 2;

  localparam logic [7:0] PROLOGUE [PROLOGUE_LEN] =
    '{8'h55, 8'h48, 8'h89, 8'hE5, 8'h53, 8'h41, 8'h55, 8'h41, 8'h56, 8'h41, 8'h57};
  localparam logic [7:0] EPILOGUE [EPILOGUE_LEN] =
    '{8'h41, 8'h5F, 8'h41, 8'h5E, 8'h41, 8'h5D, 8'h5B, 8'h5D, 8'hC3};

  localparam logic [3:0] REG_MAP [11] =
    '{4'd0, 4'd7, 4'd6, 4'd2, 4'd1, 4'd8, 4'd3, 4'd13, 4'd14, 4'd15, 4'd5};

  // One decoded instruction: byte 0 goes out first.
  typedef struct packed {
    logic [3:0]            count;
    logic [MAX_BYTES-1:0][7:0] bytes;
  } desc_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_status_t;

  // Maps an eBPF register number to an x86-64 register code.
  function automatic logic [3:0] map_reg(input logic [3:0] idx);
    logic [3:0] code;
    code = 4'd0;
    if (idx <= 4'd10) begin
      code = REG_MAP[idx];
    end
    return code;
  endfunction

  function automatic logic [7:0] rex_byte(input logic [3:0] r, input logic [3:0] b);
    return X_REX_W | {5'd0, r[3], 1'b0, b[3]};
  endfunction

  function automatic logic [7:0] modrm(input logic [1:0] md, input logic [3:0] r,
                                       input logic [3:0] rm);
    return {md, r[2:0], rm[2:0]};
  endfunction

endpackage

// File: rtl/ebpfx86_front.sv
// Front end: accepts instructions, tracks the wide-load state and decodes
// each item into a byte descriptor for the queue. Uses ebpfx86_pkg.
`include "assert_macros.svh"

module ebpfx86_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [63:0]              in_tdata,   // opcode, dst_index, src_index, offset, immediate
  input  logic [1:0]               in_tuser,   // op
  input  ebpfx86_pkg::q_status_t   q_stat,
  output logic                     push,
  output ebpfx86_pkg::desc_t       push_desc
);
  import ebpfx86_pkg::*;

  logic [7:0]  opcode;
  logic [3:0]  dst;
  logic [3:0]  src;
  logic [7:0]  off8;
  logic [31:0] imm;
  logic [2:0]  cls;
  logic [3:0]  opf;
  logic        accept;
  desc_t       desc;

  logic        wide_pending_r, wide_pending_nxt;
  logic [31:0] wide_low_r, wide_low_nxt;
  logic [3:0]  wide_tgt_r, wide_tgt_nxt;

  // Field unpacking and register mapping.
  assign opcode = in_tdata[7:0];
  assign dst    = map_reg(in_tdata[11:8]);
  assign src    = map_reg(in_tdata[15:12]);
  assign off8   = in_tdata[23:16];
  assign imm    = in_tdata[63:32];
  assign cls    = opcode[2:0];
  assign opf    = opcode[7:4];

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  // Instruction decode into bytes and a byte count.
  always_comb begin
    desc             = '0;
    wide_pending_nxt = wide_pending_r;
    wide_low_nxt     = wide_low_r;
    wide_tgt_nxt     = wide_tgt_r;
    case (op_t'(in_tuser))
      OP_START: begin
        wide_pending_nxt = 1'b0;
        for (int i = 0; i < PROLOGUE_LEN; i++) begin
          desc.bytes[i] = PROLOGUE[i];
        end
        desc.count = 4'(PROLOGUE_LEN);
      end
      OP_FINISH: begin
        wide_pending_nxt = 1'b0;
        for (int i = 0; i < EPILOGUE_LEN; i++) begin
          desc.bytes[i] = EPILOGUE[i];
        end
        desc.count = 4'(EPILOGUE_LEN);
      end
      OP_XLATE: begin
        if (wide_pending_r) begin
          // Second half of a wide load: movabs with both halves.
          wide_pending_nxt = 1'b0;
          desc.bytes[0] = rex_byte(4'd0, wide_tgt_r);
          desc.bytes[1] = X_MOV_R_IMM | {5'd0, wide_tgt_r[2:0]};
          desc.bytes[2] = wide_low_r[7:0];
          desc.bytes[3] = wide_low_r[15:8];
          desc.bytes[4] = wide_low_r[23:16];
          desc.bytes[5] = wide_low_r[31:24];
          desc.bytes[6] = imm[7:0];
          desc.bytes[7] = imm[15:8];
          desc.bytes[8] = imm[23:16];
          desc.bytes[9] = imm[31:24];
          desc.count    = 4'd10;
        end else if (cls == CLS_ALU64 && (opf inside {OPF_MOV, OPF_ADD})) begin
          if (opcode[3]) begin
            desc.bytes[0] = rex_byte(src, dst);
            desc.bytes[1] = (opf == OPF_MOV) ? X_MOV_RM_R : X_ADD_RM_R;
            desc.bytes[2] = modrm(2'd3, src, dst);
            desc.count    = 4'd3;
          end else begin
            desc.bytes[0] = rex_byte(4'd0, dst);
            desc.bytes[1] = (opf == OPF_MOV) ? X_MOV_RM_I : X_ADD_RM_I;
            desc.bytes[2] = modrm(2'd3, 4'd0, dst);
            desc.bytes[3] = imm[7:0];
            desc.bytes[4] = imm[15:8];
            desc.bytes[5] = imm[23:16];
            desc.bytes[6] = imm[31:24];
            desc.count    = 4'd7;
          end
        end else if (cls == CLS_JMP && opf == OPF_EXIT) begin
          for (int i = 0; i < EPILOGUE_LEN; i++) begin
            desc.bytes[i] = EPILOGUE[i];
          end
          desc.count = 4'(EPILOGUE_LEN);
        end else if (cls == CLS_JMP && opf == OPF_JA) begin
          // Jump with a zero displacement; the remaining bytes stay zero.
          desc.bytes[0] = X_JMP_REL32;
          desc.count    = 4'd5;
        end else if (opcode == WIDE_OPCODE) begin
          wide_pending_nxt = 1'b1;
          wide_low_nxt     = imm;
          wide_tgt_nxt     = dst;
        end else if (cls == CLS_STX && opcode[4:3] == SIZE_DW) begin
          desc.bytes[0] = rex_byte(src, dst);
          desc.bytes[1] = X_MOV_RM_R;
          desc.bytes[2] = modrm(2'd1, src, dst);
          desc.bytes[3] = off8;
          desc.count    = 4'd4;
        end else if (cls == CLS_LDX && opcode[4:3] == SIZE_DW) begin
          desc.bytes[0] = rex_byte(dst, src);
          desc.bytes[1] = X_MOV_R_RM;
          desc.bytes[2] = modrm(2'd1, dst, src);
          desc.bytes[3] = off8;
          desc.count    = 4'd4;
        end
      end
      default: begin
        // Reserved kind: no bytes and no state change.
        desc = '0;
      end
    endcase
  end

  // Items that produce no bytes are not queued.
  assign push      = accept && (desc.count != 4'd0);
  assign push_desc = desc;

  // Wide-load state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_pending_r <= 1'b0;
      wide_low_r     <= '0;
      wide_tgt_r     <= '0;
    end else if (accept) begin
      wide_pending_r <= wide_pending_nxt;
      wide_low_r     <= wide_low_nxt;
      wide_tgt_r     <= wide_tgt_nxt;
    end
  end

  `EBPF_ASSERT_NEXT(a_start_clears_wide, clk, rst_n,
    accept && (in_tuser == OP_START || in_tuser == OP_FINISH), !wide_pending_r)
  `EBPF_ASSERT_NEXT(a_wide_set_by_wide_op, clk, rst_n,
    accept && !wide_pending_r && in_tuser == OP_XLATE && opcode == WIDE_OPCODE,
    wide_pending_r)

endmodule

// File: rtl/ebpfx86_queue.sv
// Short descriptor queue between the decoding front and the byte back end.
// Uses ebpfx86_pkg for the descriptor and status types.
`include "assert_macros.svh"

module ebpfx86_queue #(
  parameter int DEPTH = ebpfx86_pkg::Q_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ebpfx86_pkg::desc_t     push_desc,
  input  logic                   pop,
  output ebpfx86_pkg::desc_t     pop_desc,
  output ebpfx86_pkg::q_status_t q_stat
);
  import ebpfx86_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t            store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full      = (count_r == CNT_W'(DEPTH));
  assign q_stat.not_empty = (count_r != '0);
  assign do_push  = push && !q_stat.full;
  assign do_pop   = pop && q_stat.not_empty;
  assign pop_desc = store_r[rd_ptr_r];

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_desc;
    end
  end

  `EBPF_ASSERT(a_no_push_when_full, clk, rst_n, !(push && q_stat.full))
  `EBPF_ASSERT(a_count_in_range, clk, rst_n, count_r <= CNT_W'(DEPTH))

endmodule

// File: rtl/ebpfx86_back.sv
// Back end: takes descriptors from the queue and shifts their bytes out
// one per cycle while out_tready is high, from a registered output stage. Uses ebpfx86_pkg.
`include "assert_macros.svh"

module ebpfx86_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ebpfx86_pkg::q_status_t q_stat,
  input  ebpfx86_pkg::desc_t     pop_desc,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,  // code_byte
  output logic                   out_tlast   // last
);
  import ebpfx86_pkg::*;

  logic [MAX_BYTES-1:0][7:0] cur_bytes_r, cur_bytes_nxt;
  logic [3:0]                cur_cnt_r, cur_cnt_nxt;
  logic                      fire;
  logic                      need_load;

  assign out_tvalid = (cur_cnt_r != 4'd0);
  assign out_tdata  = cur_bytes_r[0];
  assign out_tlast  = (cur_cnt_r == 4'd1);
  assign fire       = out_tvalid && out_tready;

  // Load a new descriptor when the stage is empty or its final byte leaves.
  assign need_load = !out_tvalid || (fire && out_tlast);
  assign pop       = need_load && q_stat.not_empty;

  always_comb begin
    cur_bytes_nxt = cur_bytes_r;
    cur_cnt_nxt   = cur_cnt_r;
    if (pop) begin
      cur_bytes_nxt = pop_desc.bytes;
      cur_cnt_nxt   = pop_desc.count;
    end else if (need_load) begin
      cur_cnt_nxt = 4'd0;
    end else if (fire) begin
      cur_bytes_nxt = cur_bytes_r >> 8;
      cur_cnt_nxt   = cur_cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_cnt_r <= 4'd0;
    end else begin
      cur_cnt_r <= cur_cnt_nxt;
    end
  end

  // Byte payload carries no reset.
  always_ff @(posedge clk) begin
    cur_bytes_r <= cur_bytes_nxt;
  end

  `EBPF_ASSERT_NEXT(a_count_steps_down, clk, rst_n,
    fire && cur_cnt_r > 4'd1, cur_cnt_r == $past(cur_cnt_r) - 4'd1)

endmodule

// File: rtl/ebpf_to_x86_64_translator_core.sv
// Translator top level: eBPF instructions in, x86-64 code bytes out.
// A new instruction is accepted every cycle while the descriptor queue has room.
// The first byte of an item is offered once it has passed through the descriptor queue and been
// loaded into the back end's output register; an item of n bytes (3 to 11) is sent one byte per
// cycle while out_tready is high, from the back end's shift register, which sets throughput.
// Synchronous active-low reset empties the queue and output and clears wide-load state.
module ebpf_to_x86_64_translator_core #(
  parameter int QUEUE_DEPTH = ebpfx86_pkg::Q_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // opcode[7:0], dst_index[11:8], src_index[15:12],
                                  // offset[31:16], immediate[63:32]
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // code_byte
  output logic        out_tlast   // last
);
  import ebpfx86_pkg::*;

  q_status_t q_stat;
  desc_t     push_desc;
  desc_t     pop_desc;
  logic      push;
  logic      pop;

  // Decode side.
  ebpfx86_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_desc (push_desc)
  );

  // Decoupling queue.
  ebpfx86_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .q_stat    (q_stat)
  );

  // Byte emission side.
  ebpfx86_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_desc   (pop_desc),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
